@@ rtl/core/kdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kdp_pkg;

	// sizing of the best-value row
	localparam int MAX_CAPACITY = 1023;
	localparam int VALUE_BITS   = 32;
	localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
	localparam int ADDR_BITS    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int SUM_BITS     = VALUE_BITS + 1;
	localparam int CMP_BITS     = 17;

	// fixed field widths
	localparam int CAP_BITS    = 10;
	localparam int WEIGHT_BITS = 10;
	localparam int PRICE_BITS  = 16;
	localparam int OUT_BITS    = 32;

	// input operation codes
	typedef enum logic [0:0] {
		OP_ADD    = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN_RD,
		ST_FIN_OUT,
		ST_CLEAR
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic cnt_load_max;
		logic cnt_dec;
		logic sweep_en;
		logic clear_en;
		logic fin_rd;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cnt_zero;
		logic cnt_at_wt;
		logic heavy;
		logic out_busy;
	} stat_t;

	// clamp a row value to the output range
	function automatic logic [OUT_BITS-1:0] clamp_out(input logic [VALUE_BITS-1:0] v);
		logic [63:0] ext;
		begin
			ext = 64'(v);
			if (ext > 64'hFFFF_FFFF) begin
				return '1;
			end
			return ext[OUT_BITS-1:0];
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/zero_one_knapsack_dp.sv @@
// channel  handshake               payload
// -------  ----------------------  --------------------------------
// cfg      cfg_valid / cfg_ready   capacity
// in       in_valid / in_ready     op, item_weight, item_price
// out      out_valid / out_ready   best_value
//
// an add item sweeps the row one entry per cycle, top index down to the item weight,
// through the two-read, one-write row memory, between a load and a drain
// a finish item is taken and its answer read into the output register, then the whole row is cleared
// an item heavier than the row is taken and changes nothing
// after reset the whole row is cleared before in_ready rises
// a finish waits while an earlier item sits unclaimed in the output register
`timescale 1ns / 1ps
`default_nettype none

module zero_one_knapsack_dp
	import kdp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CAP_BITS-1:0]    capacity,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   op,
	input  wire logic [WEIGHT_BITS-1:0] item_weight,
	input  wire logic [PRICE_BITS-1:0]  item_price,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_BITS-1:0]         best_value
);

	cmd_t  cmd;
	stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	kdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (op),
		.out_ready(out_ready),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	kdp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.capacity   (capacity),
		.item_weight(item_weight),
		.item_price (item_price),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.best_value (best_value)
	);

endmodule

`default_nettype wire

@@ rtl/core/kdp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_b,
	output logic      [WIDTH-1:0]                 rdata_a,
	output logic      [WIDTH-1:0]                 rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ rtl/core/kdp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kdp_ctrl
	import kdp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_op,
	input  wire logic out_ready,
	input  wire stat_t stat,
	output logic      in_ready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// state register, reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_FINISH) begin
						state_d = ST_FIN_RD;
					end else if (!stat.heavy) begin
						cmd.load_item    = 1'b1;
						cmd.cnt_load_max = 1'b1;
						state_d          = ST_SWEEP;
					end
				end
			end
			// one row entry issued per cycle, top index down to the weight
			ST_SWEEP: begin
				cmd.sweep_en = 1'b1;
				if (stat.cnt_at_wt) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.cnt_dec = 1'b1;
				end
			end
			// last write leaves the pipe
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			ST_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_d    = ST_FIN_OUT;
			end
			// wait for the output slot, then start clearing
			ST_FIN_OUT: begin
				cmd.fin_rd = 1'b1;
				if (!stat.out_busy || out_ready) begin
					cmd.out_load     = 1'b1;
					cmd.cnt_load_max = 1'b1;
					state_d          = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (stat.cnt_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.cnt_dec = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/kdp_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kdp_dpath
	import kdp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [CAP_BITS-1:0]    capacity,
	input  wire logic [WEIGHT_BITS-1:0] item_weight,
	input  wire logic [PRICE_BITS-1:0]  item_price,
	input  wire logic                   out_ready,
	input  wire cmd_t                   cmd,
	output stat_t                       stat,
	output logic                        out_valid,
	output logic [OUT_BITS-1:0]         best_value
);

	logic [CAP_BITS-1:0]    cap_q;
	logic [ADDR_BITS-1:0]   cnt_q;
	logic [ADDR_BITS-1:0]   wt_q;
	logic [PRICE_BITS-1:0]  price_q;
	logic                   valid_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    best_value_q;

	logic [ADDR_BITS-1:0]   cap_addr;
	logic [ADDR_BITS-1:0]   raddr_a;
	logic [ADDR_BITS-1:0]   raddr_b;
	logic [VALUE_BITS-1:0]  rdata_a;
	logic [VALUE_BITS-1:0]  rdata_b;
	logic [SUM_BITS-1:0]    sum;
	logic [VALUE_BITS-1:0]  take;
	logic [VALUE_BITS-1:0]  upd;
	logic                   we;
	logic [ADDR_BITS-1:0]   waddr;
	logic [VALUE_BITS-1:0]  wdata;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_valid) begin
			cap_q <= capacity;
		end
	end

	// capacity beyond the row reads the top entry
	assign cap_addr = (CMP_BITS'(cap_q) > CMP_BITS'(MAX_CAPACITY)) ?
		ADDR_BITS'(MAX_CAPACITY) : ADDR_BITS'(cap_q);

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			wt_q    <= ADDR_BITS'(item_weight);
			price_q <= item_price;
		end
	end

	// row index counter, shared by sweep and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= ADDR_BITS'(MAX_CAPACITY);
		end else if (cmd.cnt_load_max) begin
			cnt_q <= ADDR_BITS'(MAX_CAPACITY);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - ADDR_BITS'(1);
		end
	end

	// read addresses: entry j and entry j minus weight
	assign raddr_a = cmd.fin_rd ? cap_addr : cnt_q;
	assign raddr_b = cnt_q - wt_q;

	// write-back stage tracks the entry being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.sweep_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
	end

	// saturating take value and max
	assign sum  = {1'b0, rdata_b} + SUM_BITS'(price_q);
	assign take = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
	assign upd  = (take > rdata_a) ? take : rdata_a;

	assign we    = valid_s1 | cmd.clear_en;
	assign waddr = cmd.clear_en ? cnt_q : addr_s1;
	assign wdata = cmd.clear_en ? '0 : upd;

	kdp_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(ROW_DEPTH)
	) u_row (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			best_value_q <= clamp_out(rdata_a);
		end
	end

	assign out_valid  = out_valid_q;
	assign best_value = best_value_q;

	// status to the controller
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.cnt_at_wt = (cnt_q == wt_q);
	assign stat.heavy     = (CMP_BITS'(item_weight) > CMP_BITS'(MAX_CAPACITY));
	assign stat.out_busy  = out_valid_q;

endmodule

`default_nettype wire
